// ===== hdl/uartrx_pkg.sv =====
// ----------------------------------------------------------------------------
// uartrx_pkg: shared types and constants of the UART receiver with FIFO
// Holds the receiver phase codes, the operation passed from the receiver to
// the FIFO side, the result beat and the status of the small queues.
// ----------------------------------------------------------------------------
package uartrx_pkg;

    localparam int TICK_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;
    localparam int FILL_W      = 6;
    localparam int PHASE_W     = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCOUNT_W    = 2;

    localparam logic [TICK_W-1:0]    BIT_TICKS_RESET = 16'd104;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT        = 3'd7;

    // Receiver phase codes.
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HALF = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;
    localparam logic [PHASE_W-1:0] PH_STOP = 2'd3;

    // One sample tick, classified by the receiver for the FIFO side.
    typedef struct packed {
        logic              pop;
        logic              push;
        logic [BYTE_W-1:0] push_byte;
    } op_t;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic [FILL_W-1:0] fill_count;
        logic              overflow_flag;
    } result_t;

    // Occupancy of a small queue and whether its head leaves this cycle.
    typedef struct packed {
        logic [QCOUNT_W-1:0] count;
        logic                deq;
    } q_status_t;

    localparam int OP_W     = $bits(op_t);
    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hdl/uartrx_ram.sv =====
// ----------------------------------------------------------------------------
// uartrx_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module uartrx_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/uartrx_queue.sv =====
// ----------------------------------------------------------------------------
// uartrx_queue: two-entry queue with valid/ready on both sides
// Decouples two parts of the pipeline; reports its occupancy.
// ----------------------------------------------------------------------------
module uartrx_queue
    import uartrx_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             enq_valid,
    output logic             enq_ready,
    input  logic [WIDTH-1:0] enq_data,
    output logic             deq_valid,
    input  logic             deq_ready,
    output logic [WIDTH-1:0] deq_data,
    output q_status_t        status
);

    logic [WIDTH-1:0]    slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;
    logic                enq_fire;
    logic                deq_fire;

    assign enq_ready = (count_reg != QCOUNT_W'(QUEUE_DEPTH));
    assign deq_valid = (count_reg != '0);
    assign enq_fire  = enq_valid && enq_ready;
    assign deq_fire  = deq_valid && deq_ready;
    assign deq_data  = slot_reg[head_reg];

    always_comb begin
        head_next  = deq_fire ? head_reg + QPTR_W'(1) : head_reg;
        tail_next  = enq_fire ? tail_reg + QPTR_W'(1) : tail_reg;
        count_next = count_reg + QCOUNT_W'(enq_fire) - QCOUNT_W'(deq_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq_fire) begin
            slot_reg[tail_reg] <= enq_data;
        end
    end

    assign status.count = count_reg;
    assign status.deq   = deq_fire;

endmodule

// ===== hdl/uartrx_front.sv =====
// ----------------------------------------------------------------------------
// uartrx_front: 8N1 receive state machine
// Advances once per accepted sample tick and turns each tick into a FIFO
// operation: the pop request and, at the last data bit, a byte to push.
// ----------------------------------------------------------------------------
module uartrx_front
    import uartrx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [TICK_W-1:0] cfg_data,
    input  logic              tick_accept,
    input  logic              rx_line,
    input  logic              pop_request,
    output op_t               op
);

    logic [TICK_W-1:0]    bit_ticks_reg;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_cnt_reg, tick_cnt_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [TICK_W-1:0]    half_ticks;
    logic [TICK_W-1:0]    tick_inc;
    logic                 push;

    assign half_ticks = bit_ticks_reg >> 1;
    assign tick_inc   = tick_cnt_reg + TICK_W'(1);

    always_comb begin
        phase_next    = phase_reg;
        tick_cnt_next = tick_cnt_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        push          = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (!rx_line) begin
                    tick_cnt_next = '0;
                    bit_idx_next  = '0;
                    shift_next    = '0;
                    phase_next    = (half_ticks == '0) ? PH_DATA : PH_HALF;
                end
            end
            PH_HALF: begin
                tick_cnt_next = tick_inc;
                if (tick_inc >= half_ticks) begin
                    tick_cnt_next = '0;
                    phase_next    = PH_DATA;
                end
            end
            PH_DATA: begin
                tick_cnt_next = tick_inc;
                if (tick_inc >= bit_ticks_reg) begin
                    tick_cnt_next = '0;
                    shift_next    = {rx_line, shift_reg[BYTE_W-1:1]};
                    if (bit_idx_reg == LAST_BIT) begin
                        bit_idx_next = '0;
                        push         = 1'b1;
                        phase_next   = PH_STOP;
                    end else begin
                        bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                    end
                end
            end
            PH_STOP: begin
                tick_cnt_next = tick_inc;
                if (tick_inc >= bit_ticks_reg) begin
                    tick_cnt_next = '0;
                    phase_next    = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= BIT_TICKS_RESET;
            phase_reg     <= PH_IDLE;
            tick_cnt_reg  <= '0;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                bit_ticks_reg <= cfg_data;
            end
            if (tick_accept) begin
                phase_reg    <= phase_next;
                tick_cnt_reg <= tick_cnt_next;
                bit_idx_reg  <= bit_idx_next;
                shift_reg    <= shift_next;
            end
        end
    end

    assign op.pop       = pop_request;
    assign op.push      = push;
    assign op.push_byte = shift_next;

endmodule

// ===== hdl/uartrx_back.sv =====
// ----------------------------------------------------------------------------
// uartrx_back: receive FIFO engine
// Takes one operation per cycle while the output has room, serves the pop
// before the push, keeps one slot empty, and forms the result beat once the
// RAM read data is back.
module uartrx_back
    import uartrx_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      op_valid,
    output logic      op_ready,
    input  op_t       op,
    input  q_status_t out_st,
    output logic      res_valid,
    output result_t   res
);

    localparam int ADDR_W = $clog2(FIFO_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FIFO_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_W   = (ADDR_W + 1)'(FIFO_DEPTH);

    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              ovf_reg, ovf_next;
    logic              p1_valid_reg;
    logic              p1_rvalid_reg;
    logic [FILL_W-1:0] p1_fill_reg;
    logic              p1_ovf_reg;
    logic              issue;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] rp_inc;
    logic [ADDR_W-1:0] wp_inc;
    logic [ADDR_W-1:0] rp_after_pop;
    logic [ADDR_W:0]   fill_wide;
    logic [BYTE_W-1:0] rd_data;

    // Room check: the result in flight always finds a free output slot.
    assign issue    = op_valid &&
                      (({1'b0, out_st.count} + {2'b0, p1_valid_reg}) <
                       (3'd2 + {2'b0, out_st.deq}));
    assign op_ready = issue;

    always_comb begin
        rp_inc       = (rp_reg == LAST_ADDR) ? '0 : rp_reg + ADDR_W'(1);
        wp_inc       = (wp_reg == LAST_ADDR) ? '0 : wp_reg + ADDR_W'(1);
        rd_en        = issue && op.pop && (rp_reg != wp_reg);
        rp_after_pop = rd_en ? rp_inc : rp_reg;
        wr_en        = 1'b0;
        wp_next      = wp_reg;
        ovf_next     = ovf_reg;
        if (issue && op.push) begin
            if (wp_inc != rp_after_pop) begin
                wr_en   = 1'b1;
                wp_next = wp_inc;
            end else begin
                ovf_next = 1'b1;
            end
        end
        rp_next   = rp_after_pop;
        fill_wide = {1'b0, wp_next} - {1'b0, rp_next} +
                    ((wp_next < rp_next) ? DEPTH_W : '0);
    end

    uartrx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (op.push_byte),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg       <= '0;
            wp_reg       <= '0;
            ovf_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            ovf_reg      <= ovf_next;
            p1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_rvalid_reg <= rd_en;
            p1_fill_reg   <= FILL_W'(fill_wide);
            p1_ovf_reg    <= ovf_next;
        end
    end

    assign res_valid         = p1_valid_reg;
    assign res.read_data     = p1_rvalid_reg ? rd_data : '0;
    assign res.read_valid    = p1_rvalid_reg;
    assign res.fill_count    = p1_fill_reg;
    assign res.overflow_flag = p1_ovf_reg;

    a_out_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (({1'b0, out_st.count} + {2'b0, p1_valid_reg}) <= 3'd2))
        else $error("result in flight without a free output slot");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared without reset");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rp_reg != wp_reg) && !(wr_en && (wp_reg == rp_reg)))
        else $error("FIFO read while empty or colliding with write");

    a_full_keeps_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (wp_reg != rp_reg))
        else $error("push filled the spare slot");

endmodule

// ===== hdl/uart_receiver_with_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_receiver_with_fifo: 8N1 UART receiver with a receive FIFO
// One sample tick per input beat; each tick returns one result beat with the
// popped byte, the FIFO fill and the sticky overflow flag.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake             Payload
//  -------  ---  --------------------  --------------------------------------
//  s_       in   s_valid / s_ready     s_rx_line, s_pop_request
//  m_       out  m_valid / m_ready     m_read_data, m_read_valid,
//                                      m_fill_count, m_overflow_flag
//  cfg_     in   cfg_valid / cfg_ready cfg_data (bit_ticks)
//
//  One tick beat is accepted per clock and one result beat leaves per clock
//  while neither side stalls.
//  The rate is set by the single RAM read port: one pop per cycle.
//  Reset (aresetn low, synchronous) returns to idle with an empty FIFO and
//  bit_ticks at 104; FIFO contents are not cleared and no sweep is needed.
//  Two-entry queues between receiver, FIFO engine and output let each side
//  stall on its own; s_ready drops only when both queues back up.
//
module uart_receiver_with_fifo
    import uartrx_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write (bit_ticks)
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_data,
    // Sample ticks
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_rx_line,
    input  logic              s_pop_request,
    // Results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_read_data,
    output logic              m_read_valid,
    output logic [FILL_W-1:0] m_fill_count,
    output logic              m_overflow_flag
);

    op_t             front_op;
    op_t             back_op;
    logic [OP_W-1:0] back_op_bits;
    logic            tick_accept;
    logic            back_op_valid;
    logic            back_op_ready;
    logic            res_valid;
    result_t         res;
    logic [RESULT_W-1:0] out_bits;
    result_t         out_res;
    q_status_t       out_st;

    // The bit time register is written directly, so a write is never held.
    assign cfg_ready   = 1'b1;
    assign tick_accept = s_valid && s_ready;

    // Receiver: runs the frame timing on every accepted tick and classifies
    // the tick into a pop request and an optional byte push.
    uartrx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .tick_accept (tick_accept),
        .rx_line     (s_rx_line),
        .pop_request (s_pop_request),
        .op          (front_op)
    );

    // Operation queue: the receiver keeps taking ticks while the FIFO engine
    // waits for room at the output.
    uartrx_queue #(
        .WIDTH (OP_W)
    ) u_op_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enq_valid (tick_accept),
        .enq_ready (s_ready),
        .enq_data  (front_op),
        .deq_valid (back_op_valid),
        .deq_ready (back_op_ready),
        .deq_data  (back_op_bits),
        .status    ()
    );

    assign back_op = op_t'(back_op_bits);

    // FIFO engine: pop first, then push, with the RAM read data registered.
    uartrx_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (back_op_valid),
        .op_ready  (back_op_ready),
        .op        (back_op),
        .out_st    (out_st),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output queue: holds finished results while the consumer stalls. The
    // FIFO engine only issues when a slot is guaranteed, so enq never waits.
    uartrx_queue #(
        .WIDTH (RESULT_W)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enq_valid (res_valid),
        .enq_ready (),
        .enq_data  (res),
        .deq_valid (m_valid),
        .deq_ready (m_ready),
        .deq_data  (out_bits),
        .status    (out_st)
    );

    assign out_res         = result_t'(out_bits);
    assign m_read_data     = out_res.read_data;
    assign m_read_valid    = out_res.read_valid;
    assign m_fill_count    = out_res.fill_count;
    assign m_overflow_flag = out_res.overflow_flag;

endmodule

// ===== dv/uartrx_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uartrx_checker: result predictor and comparator for the UART receiver
// Watches the configuration, sample tick and result channels, keeps its own
// copy of the receiver and FIFO state, and compares every result beat with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module uartrx_checker
    import uartrx_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_rx_line,
    input  logic              s_pop_request,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [BYTE_W-1:0] m_read_data,
    input  logic              m_read_valid,
    input  logic [FILL_W-1:0] m_fill_count,
    input  logic              m_overflow_flag,
    output int                error_count,
    output int                results_pending,
    output int                results_checked,
    output int                bytes_popped,
    output logic              overflow_seen
);

    localparam int MAX_PRINTED = 100;

    logic [TICK_W-1:0]    ticks_per_bit;
    logic [PHASE_W-1:0]   rx_state;
    logic [TICK_W-1:0]    tick_cnt;
    logic [BIT_IDX_W-1:0] bits_taken;
    logic [BYTE_W-1:0]    shift_reg;
    logic [BYTE_W-1:0]    byte_mem [FIFO_DEPTH];
    int                   head_idx;
    int                   tail_idx;
    logic                 byte_lost;
    result_t              due_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED) begin
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // One sample tick: the pop is served first, then the receiver advances.
    task automatic receive_tick(input logic line, input logic pop, output result_t beat);
        logic [TICK_W-1:0] half;
        int                nxt;
        half = ticks_per_bit >> 1;
        beat = '0;
        if (pop && head_idx != tail_idx) begin
            beat.read_data  = byte_mem[head_idx];
            beat.read_valid = 1'b1;
            head_idx        = (head_idx + 1) % FIFO_DEPTH;
        end
        case (rx_state)
            PH_IDLE: begin
                if (!line) begin
                    tick_cnt   = '0;
                    bits_taken = '0;
                    shift_reg  = '0;
                    rx_state   = (half == 0) ? PH_DATA : PH_HALF;
                end
            end
            PH_HALF: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= half) begin
                    tick_cnt = '0;
                    rx_state = PH_DATA;
                end
            end
            PH_DATA: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= ticks_per_bit) begin
                    tick_cnt  = '0;
                    shift_reg = {line, shift_reg[BYTE_W-1:1]};
                    if (bits_taken == LAST_BIT) begin
                        bits_taken = '0;
                        rx_state   = PH_STOP;
                        // The ring keeps one slot free; a push into it is lost.
                        nxt = (tail_idx + 1) % FIFO_DEPTH;
                        if (nxt != head_idx) begin
                            byte_mem[tail_idx] = shift_reg;
                            tail_idx           = nxt;
                        end else begin
                            byte_lost = 1'b1;
                        end
                    end else begin
                        bits_taken = bits_taken + 1'b1;
                    end
                end
            end
            default: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= ticks_per_bit) begin
                    tick_cnt = '0;
                    rx_state = PH_IDLE;
                end
            end
        endcase
        beat.fill_count    = FILL_W'((tail_idx + FIFO_DEPTH - head_idx) % FIFO_DEPTH);
        beat.overflow_flag = byte_lost;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            ticks_per_bit   = BIT_TICKS_RESET;
            rx_state        = PH_IDLE;
            tick_cnt        = '0;
            bits_taken      = '0;
            shift_reg       = '0;
            head_idx        = 0;
            tail_idx        = 0;
            byte_lost       = 1'b0;
            error_count     = 0;
            results_checked = 0;
            bytes_popped    = 0;
            overflow_seen   = 1'b0;
            due_results.delete();
        end else begin
            // A result only leaves after its tick is queued and registered, so the
            // beat is compared before this edge's tick is predicted.
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_read_data, 0);
                end else begin
                    want = due_results.pop_front();
                    results_checked++;
                    if (want.read_valid) bytes_popped++;
                    if (m_overflow_flag) overflow_seen = 1'b1;
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", m_read_data, want.read_data);
                    if (m_read_valid !== want.read_valid)
                        report_mismatch("read_valid", m_read_valid, want.read_valid);
                    if (m_fill_count !== want.fill_count)
                        report_mismatch("fill_count", m_fill_count, want.fill_count);
                    if (m_overflow_flag !== want.overflow_flag)
                        report_mismatch("overflow_flag", m_overflow_flag, want.overflow_flag);
                end
            end
            if (cfg_valid && cfg_ready) ticks_per_bit = cfg_data;
            if (s_valid && s_ready) begin
                receive_tick(s_rx_line, s_pop_request, want);
                due_results.push_back(want);
            end
        end
        results_pending = due_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the UART receiver with receive FIFO
// Feeds serial frames, glitched frames and line noise as sample ticks at
// several bit times, with random pops, idle gaps on both channels and one
// long output stall; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import uartrx_pkg::*;

    localparam int FIFO_DEPTH     = 64;
    // Longest legal quiet stretch is the long output stall; allow ten times it.
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    // Extra pause after the last result is back, as margin.
    localparam int DRAIN_PAUSE    = 4;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [TICK_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_rx_line;
    logic              s_pop_request;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_read_data;
    logic              m_read_valid;
    logic [FILL_W-1:0] m_fill_count;
    logic              m_overflow_flag;

    int   error_count;
    int   results_pending;
    int   results_checked;
    int   bytes_popped;
    logic overflow_seen;

    int   ticks_sent;
    int   cfg_writes;
    int   cur_ticks;
    // When set, the sender offers beats back to back for the current frame.
    bit   tx_steady;
    // Raised by the stimulus, cleared by the receiver once its long stall ends.
    bit   hold_req;

    int unsigned ticks_list [5] = '{7, 5, 2, 3, 6};

    always #4 aclk = ~aclk;

    uart_receiver_with_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_line      (s_rx_line),
        .s_pop_request  (s_pop_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_read_valid   (m_read_valid),
        .m_fill_count   (m_fill_count),
        .m_overflow_flag(m_overflow_flag)
    );

    uartrx_checker #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_line      (s_rx_line),
        .s_pop_request  (s_pop_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_read_valid   (m_read_valid),
        .m_fill_count   (m_fill_count),
        .m_overflow_flag(m_overflow_flag),
        .error_count    (error_count),
        .results_pending(results_pending),
        .results_checked(results_checked),
        .bytes_popped   (bytes_popped),
        .overflow_seen  (overflow_seen)
    );

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // A bit time of zero behaves as one tick per bit.
    function automatic int bit_span();
        return (cur_ticks == 0) ? 1 : cur_ticks;
    endfunction

    // Offers one sample tick beat. Inputs change only at the falling edge, and
    // valid is lowered only inside an idle gap, so a beat that follows another
    // without a gap keeps valid high through the step.
    task automatic send_tick(input logic line, input logic pop);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_line     <= line;
        s_pop_request <= pop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        ticks_sent++;
    endtask

    // One serial bit at the current bit time; glitch_pct flips single ticks.
    task automatic send_bit(input logic level, input int pop_pct, input int glitch_pct);
        repeat (bit_span()) send_tick(level ^ chance(glitch_pct), chance(pop_pct));
    endtask

    // An 8N1 frame, least significant bit first, then a short idle stretch.
    task automatic send_frame(input logic [BYTE_W-1:0] value, input int pop_pct,
                              input int glitch_pct);
        int i;
        send_bit(1'b0, pop_pct, glitch_pct);
        for (i = 0; i < BYTE_W; i++) send_bit(value[i], pop_pct, glitch_pct);
        send_bit(1'b1, pop_pct, glitch_pct);
        repeat ($urandom_range(0, 3)) send_tick(1'b1, chance(pop_pct));
    endtask

    // Mostly clean frames with random bytes, some glitched frames and some
    // bursts of raw line noise, until the tick budget is used up.
    task automatic run_traffic(input int budget, input int pop_pct);
        int start;
        int kind;
        start = ticks_sent;
        while (ticks_sent - start < budget) begin
            tx_steady = chance(25);
            kind      = $urandom_range(0, 9);
            if (kind < 7) begin
                send_frame(BYTE_W'($urandom_range(0, 255)), pop_pct, 0);
            end else if (kind < 9) begin
                send_frame(BYTE_W'($urandom_range(0, 255)), pop_pct, 10);
            end else begin
                repeat ($urandom_range(2, 3 * bit_span()))
                    send_tick(1'($urandom_range(0, 1)), chance(pop_pct));
            end
        end
    endtask

    // Stops offering ticks and waits until every result beat is back.
    task automatic drain();
        s_valid <= 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    // The bit time register is written only with nothing in flight.
    task automatic set_bit_ticks(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= TICK_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_ticks = value;
        cfg_writes++;
    endtask

    // Result side: random ready gaps, stretches without gaps, and one long
    // stall on request so that the block backs up and drops s_ready.
    initial begin
        int gap;
        int beats_left;
        bit rx_steady;
        m_ready    = 1'b0;
        beats_left = 0;
        rx_steady  = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (beats_left == 0) begin
                rx_steady  = chance(25);
                beats_left = $urandom_range(8, 40);
            end
            gap = rx_steady ? 0 : $urandom_range(0, 4);
            repeat (gap) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
            beats_left--;
        end
    end

    // Watchdog: any cycle with a beat on some channel restarts the count.
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("%0t: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int k;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_rx_line     = 1'b1;
        s_pop_request = 1'b0;
        ticks_sent    = 0;
        cfg_writes    = 0;
        cur_ticks     = int'(BIT_TICKS_RESET);
        tx_steady     = 1'b0;
        hold_req      = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Pops on an empty FIFO at the reset bit time must
        // return zero with read_valid low and change nothing.
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        // A zero bit time has no half-bit wait and samples on every tick;
        // an all-zero byte checks the lowest data value.
        set_bit_ticks(0);
        send_frame(8'h00, 0, 0);
        // One tick per bit again, now with an all-ones byte.
        set_bit_ticks(1);
        send_frame(8'hFF, 0, 0);
        // Pop both bytes back, then one more pop on the now empty FIFO.
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);

        // Largest bit time: a start bit leaves the receiver deep in its
        // half-bit wait. Shrinking the bit time there ends the wait at once,
        // since the counter is already past the new half bit.
        set_bit_ticks(16'hFFFF);
        send_tick(1'b0, 1'b0);
        repeat (40) send_tick(1'($urandom_range(0, 1)), chance(30));
        set_bit_ticks(4);

        // Bit time of four ticks, with one long stall on the result side
        // while ticks keep coming, so that the input is held off.
        hold_req = 1'b1;
        run_traffic(100, 30);

        for (k = 0; k < 5; k++) begin
            set_bit_ticks(ticks_list[k]);
            run_traffic(30, $urandom_range(2, 40));
        end

        // Short frames and no pops: the FIFO fills to its last free slot and
        // further bytes are lost, which sets the sticky overflow flag.
        set_bit_ticks(1);
        run_traffic(720, 0);
        // Idle line while the FIFO is read back down to empty.
        tx_steady = 1'b0;
        repeat (80) send_tick(1'b1, chance(90));

        set_bit_ticks(4);
        run_traffic(60, 50);
        drain();

        $display("testbench: %0d tick beats sent, %0d results checked, %0d bytes popped",
                 ticks_sent, results_checked, bytes_popped);
        $display("testbench: %0d bit time writes from 0 to 65535, overflow observed: %0d",
                 cfg_writes, overflow_seen);
        if (error_count == 0 && results_pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/uartrx_pkg.sv
hdl/uartrx_ram.sv
hdl/uartrx_queue.sv
hdl/uartrx_front.sv
hdl/uartrx_back.sv
hdl/uart_receiver_with_fifo.sv
dv/uartrx_checker.sv
dv/testbench.sv
